/* rtl/bpc_pkg.sv */
// ----------------------------------------------------------------------------
// bpc_pkg
// Types and constants for the barometric pressure compensation pipeline:
// calibration register map and reset words, shift amounts, temperature
// thresholds and fixed-point widths.
// ----------------------------------------------------------------------------
package bpc_pkg;

   localparam int CAL_NUM   = 6;
   localparam int CAL_IDX_W = 3;

   typedef logic [15:0]          cal_word_type;
   typedef logic [CAL_IDX_W-1:0] cal_idx_type;

   localparam cal_idx_type CAL_SENS      = 3'd0;
   localparam cal_idx_type CAL_OFF       = 3'd1;
   localparam cal_idx_type CAL_TCS       = 3'd2;
   localparam cal_idx_type CAL_TCO       = 3'd3;
   localparam cal_idx_type CAL_TREF      = 3'd4;
   localparam cal_idx_type CAL_TEMPSENS  = 3'd5;

   localparam cal_word_type CAL_RESET [CAL_NUM] = '{
      16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312
   };

   // fixed-point widths
   localparam int RAW_W   = 24;
   localparam int DT_W    = 25;
   localparam int MP_W    = 42;
   localparam int OUT_W   = 19;
   localparam int ACC_W   = 40;
   localparam int SQ_W    = 36;
   localparam int CORR_W  = 39;
   localparam int SPLIT_W = 20;
   localparam int PPL_W   = 44;
   localparam int PPH_W   = 45;
   localparam int PROD_W  = 64;
   localparam int DIFF_W  = 44;

   // arithmetic shifts
   localparam int OFF_SHIFT   = 7;
   localparam int SENS_SHIFT  = 8;
   localparam int TEMP_SHIFT  = 23;
   localparam int PROD_SHIFT  = 21;
   localparam int PRESS_SHIFT = 15;

   typedef logic signed [OUT_W-1:0] out_type;

   localparam out_type TEMP_REF = 19'sd2000;
   localparam out_type TEMP_LOW = -19'sd1500;
   localparam out_type OUT_MAX  = 19'sd262143;
   localparam out_type OUT_MIN  = -19'sd262144;

   localparam int STAGES = 9;

endpackage

/* rtl/baro_pressure_compensation_unit.sv */
// ----------------------------------------------------------------------------
// baro_pressure_compensation_unit
// Second-order barometric compensation: dT, offset and sensitivity from six
// calibration words, low-temperature corrections, compensated pressure saturated
// to 19 bits signed and first-order temperature, 19 bits signed (truncated).
//
//   channel   direction   word
//   req_      in          tdata[23:0] raw_pressure, [47:24] raw_temperature
//   rsp_      out         tdata[18:0] pressure, [37:19] temperature, pad
//   csr_      in          csr_index selects calibration word, csr_data value
//
// a word is accepted every cycle unless a stall on rsp_ has backed up every stage
// the stage boundaries follow the multiplier levels (coefficient products,
// squares, the split 24 x 40 bit pressure product)
// synchronous reset empties the pipeline and reloads the calibration words
// a stall on rsp_ holds the last stage; earlier stages keep filling bubbles
// ----------------------------------------------------------------------------
module baro_pressure_compensation_unit
   import bpc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [47:0]           req_tdata,   // raw_pressure, raw_temperature
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [39:0]           rsp_tdata,   // pressure, temperature, pad
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CAL_IDX_W-1:0]  csr_index,
   input  logic [15:0]           csr_data
);

   cal_word_type cal_ff [CAL_NUM];

   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;
   logic [STAGES-1:0] stage_rdy;

   // stage 0
   logic [RAW_W-1:0]        d1_s0_ff;
   logic signed [DT_W-1:0]  dt_s0_ff;
   logic signed [DT_W-1:0]  dt_in;
   // stage 1
   logic [RAW_W-1:0]        d1_s1_ff;
   logic signed [MP_W-1:0]  poff_s1_ff, psens_s1_ff, ptemp_s1_ff;
   logic signed [MP_W-1:0]  poff_in, psens_in, ptemp_in;
   // stage 2
   logic [RAW_W-1:0]        d1_s2_ff;
   logic signed [ACC_W-1:0] off_s2_ff, sens_s2_ff;
   out_type                 temp_s2_ff;
   logic signed [MP_W-1:0]  poff_sh, psens_sh, ptemp_sh;
   logic signed [ACC_W-1:0] off_in, sens_in;
   out_type                 temp_in;
   // stage 3
   logic [RAW_W-1:0]        d1_s3_ff;
   logic signed [ACC_W-1:0] off_s3_ff, sens_s3_ff;
   out_type                 temp_s3_ff;
   logic [SQ_W-1:0]         sqd_s3_ff, sqe_s3_ff;
   logic                    lo_s3_ff, vlo_s3_ff;
   out_type                 dd, de;
   logic signed [2*OUT_W-1:0] sqd_full, sqe_full;
   // stage 4
   logic [RAW_W-1:0]        d1_s4_ff;
   logic signed [ACC_W-1:0] off_s4_ff, sens_s4_ff;
   out_type                 temp_s4_ff;
   logic [CORR_W-1:0]       off2_s4_ff, sens2_s4_ff;
   logic [CORR_W-1:0]       five_d, seven_e, eleven_e, off2_in, sens2_in;
   // stage 5
   logic [RAW_W-1:0]        d1_s5_ff;
   logic signed [ACC_W-1:0] offc_s5_ff, sensc_s5_ff;
   out_type                 temp_s5_ff;
   // stage 6
   logic signed [ACC_W-1:0] offc_s6_ff;
   out_type                 temp_s6_ff;
   logic [PPL_W-1:0]        pplo_s6_ff, pplo_in;
   logic signed [PPH_W-1:0] pphi_s6_ff, pphi_in;
   // stage 7
   logic signed [DIFF_W-1:0] diff_s7_ff, diff_in;
   out_type                  temp_s7_ff;
   logic signed [PROD_W-1:0] prod, prod_sh;
   // stage 8, output
   out_type                  press_ff, temperature_ff, press_in;
   logic signed [DIFF_W-1:0] press_sh;

   logic req_acc, rsp_acc;

   assign csr_ready  = 1'b1;
   assign req_tready = stage_rdy[0];
   assign rsp_tvalid = valid_ff[STAGES-1];
   assign rsp_tdata  = {2'b00, temperature_ff, press_ff};
   assign req_acc    = req_tvalid && req_tready;
   assign rsp_acc    = rsp_tvalid && rsp_tready;

   // calibration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CAL_NUM; i++) begin
            cal_ff[i] <= CAL_RESET[i];
         end
      end else if (csr_valid && csr_ready && (csr_index < CAL_IDX_W'(CAL_NUM))) begin
         cal_ff[csr_index] <= csr_data;
      end
   end

   // stage ready chain and valid bits
   always_comb begin
      stage_rdy[STAGES-1] = !valid_ff[STAGES-1] || rsp_tready;
      for (int k = STAGES-2; k >= 0; k--) begin
         stage_rdy[k] = !valid_ff[k] || stage_rdy[k+1];
      end
      valid_in[0] = stage_rdy[0] ? req_tvalid : valid_ff[0];
      for (int k = 1; k < STAGES; k++) begin
         valid_in[k] = stage_rdy[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // stage 0: dT
   assign dt_in = $signed({1'b0, req_tdata[47:24]})
                - $signed({1'b0, cal_ff[CAL_TREF], 8'h00});

   always_ff @(posedge clock) begin
      if (stage_rdy[0]) begin
         d1_s0_ff <= req_tdata[23:0];
         dt_s0_ff <= dt_in;
      end
   end

   // stage 1: coefficient products
   assign poff_in  = dt_s0_ff * $signed({1'b0, cal_ff[CAL_TCO]});
   assign psens_in = dt_s0_ff * $signed({1'b0, cal_ff[CAL_TCS]});
   assign ptemp_in = dt_s0_ff * $signed({1'b0, cal_ff[CAL_TEMPSENS]});

   always_ff @(posedge clock) begin
      if (stage_rdy[1]) begin
         d1_s1_ff    <= d1_s0_ff;
         poff_s1_ff  <= poff_in;
         psens_s1_ff <= psens_in;
         ptemp_s1_ff <= ptemp_in;
      end
   end

   // stage 2: first-order offset, sensitivity, temperature
   assign poff_sh  = poff_s1_ff >>> OFF_SHIFT;
   assign psens_sh = psens_s1_ff >>> SENS_SHIFT;
   assign ptemp_sh = ptemp_s1_ff >>> TEMP_SHIFT;
   assign off_in   = $signed({8'h00, cal_ff[CAL_OFF], 16'h0000}) + poff_sh[ACC_W-1:0];
   assign sens_in  = $signed({9'h000, cal_ff[CAL_SENS], 15'h0000}) + psens_sh[ACC_W-1:0];
   assign temp_in  = TEMP_REF + ptemp_sh[OUT_W-1:0];

   always_ff @(posedge clock) begin
      if (stage_rdy[2]) begin
         d1_s2_ff   <= d1_s1_ff;
         off_s2_ff  <= off_in;
         sens_s2_ff <= sens_in;
         temp_s2_ff <= temp_in;
      end
   end

   // stage 3: squares for the low-temperature terms
   assign dd       = temp_s2_ff - TEMP_REF;
   assign de       = temp_s2_ff - TEMP_LOW;
   assign sqd_full = dd * dd;
   assign sqe_full = de * de;

   always_ff @(posedge clock) begin
      if (stage_rdy[3]) begin
         d1_s3_ff   <= d1_s2_ff;
         off_s3_ff  <= off_s2_ff;
         sens_s3_ff <= sens_s2_ff;
         temp_s3_ff <= temp_s2_ff;
         sqd_s3_ff  <= sqd_full[SQ_W-1:0];
         sqe_s3_ff  <= sqe_full[SQ_W-1:0];
         lo_s3_ff   <= temp_s2_ff < TEMP_REF;
         vlo_s3_ff  <= temp_s2_ff < TEMP_LOW;
      end
   end

   // stage 4: OFF2 and SENS2
   assign five_d   = {1'b0, sqd_s3_ff, 2'b00} + {3'b000, sqd_s3_ff};
   assign seven_e  = {sqe_s3_ff, 3'b000} - {3'b000, sqe_s3_ff};
   assign eleven_e = {sqe_s3_ff, 3'b000} + {2'b00, sqe_s3_ff, 1'b0} + {3'b000, sqe_s3_ff};

   always_comb begin
      off2_in  = '0;
      sens2_in = '0;
      if (lo_s3_ff) begin
         off2_in  = five_d >> 1;
         sens2_in = five_d >> 2;
         if (vlo_s3_ff) begin
            off2_in  = off2_in + seven_e;
            sens2_in = sens2_in + (eleven_e >> 1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_rdy[4]) begin
         d1_s4_ff    <= d1_s3_ff;
         off_s4_ff   <= off_s3_ff;
         sens_s4_ff  <= sens_s3_ff;
         temp_s4_ff  <= temp_s3_ff;
         off2_s4_ff  <= off2_in;
         sens2_s4_ff <= sens2_in;
      end
   end

   // stage 5: corrected offset and sensitivity
   always_ff @(posedge clock) begin
      if (stage_rdy[5]) begin
         d1_s5_ff    <= d1_s4_ff;
         offc_s5_ff  <= off_s4_ff - $signed({1'b0, off2_s4_ff});
         sensc_s5_ff <= sens_s4_ff - $signed({1'b0, sens2_s4_ff});
         temp_s5_ff  <= temp_s4_ff;
      end
   end

   // stage 6: D1 * SENS as two partial products
   assign pplo_in = d1_s5_ff * sensc_s5_ff[SPLIT_W-1:0];
   assign pphi_in = $signed({1'b0, d1_s5_ff}) * $signed(sensc_s5_ff[ACC_W-1:SPLIT_W]);

   always_ff @(posedge clock) begin
      if (stage_rdy[6]) begin
         offc_s6_ff <= offc_s5_ff;
         temp_s6_ff <= temp_s5_ff;
         pplo_s6_ff <= pplo_in;
         pphi_s6_ff <= pphi_in;
      end
   end

   // stage 7: combine, scale, subtract offset
   assign prod    = $signed({pphi_s6_ff[PPH_W-2:0], {SPLIT_W{1'b0}}})
                  + $signed({{(PROD_W-PPL_W){1'b0}}, pplo_s6_ff});
   assign prod_sh = prod >>> PROD_SHIFT;
   assign diff_in = $signed(prod_sh[DIFF_W-1:0])
                  - $signed({{(DIFF_W-ACC_W){offc_s6_ff[ACC_W-1]}}, offc_s6_ff});

   always_ff @(posedge clock) begin
      if (stage_rdy[7]) begin
         diff_s7_ff <= diff_in;
         temp_s7_ff <= temp_s6_ff;
      end
   end

   // stage 8: final scale and saturation
   assign press_sh = diff_s7_ff >>> PRESS_SHIFT;

   always_comb begin
      if (!press_sh[DIFF_W-1] && (|press_sh[DIFF_W-2:OUT_W-1])) begin
         press_in = OUT_MAX;
      end else if (press_sh[DIFF_W-1] && !(&press_sh[DIFF_W-2:OUT_W-1])) begin
         press_in = OUT_MIN;
      end else begin
         press_in = press_sh[OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_rdy[8]) begin
         press_ff       <= press_in;
         temperature_ff <= temp_s7_ff;
      end
   end

   // pipeline is empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> (valid_ff == '0))
      else $error("pipeline not empty after reset");

   // input is refused only when every stage holds a word
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (&valid_ff))
      else $error("input stalled with a bubble in the pipeline");

   // words in flight change only by accepted inputs and delivered results
   a_occupancy: assert property (@(posedge clock) disable iff (reset)
      !reset |=> (($countones(valid_ff) + $past(rsp_acc))
                  == ($past($countones(valid_ff)) + $past(req_acc))))
      else $error("word lost or duplicated in pipeline");

endmodule

/* dv/bpc_compensation_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bpc_compensation_checker
// Watches the request, response and calibration channels of the barometric
// compensation unit. Tracks the calibration words written, computes the
// compensated pressure and temperature for every accepted request word in
// 64-bit fixed point and compares them in order with the response words.
// ----------------------------------------------------------------------------
module bpc_compensation_checker
   import bpc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [47:0]           req_tdata,   // raw_pressure, raw_temperature
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [39:0]           rsp_tdata,   // pressure, temperature, pad
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CAL_IDX_W-1:0]  csr_index,
   input  logic [15:0]           csr_data,
   output int                    fail_count,
   output int                    pending
);

   typedef struct {
      logic [RAW_W-1:0] raw_press;
      logic [RAW_W-1:0] raw_temp;
      out_type          pressure;
      out_type          temperature;
   } reading_type;

   cal_word_type cal_word [CAL_NUM];
   reading_type  compensated_q [$];
   int           mismatches = 0;
   int           waiting = 0;

   assign fail_count = mismatches;
   assign pending    = waiting;

   task automatic report_mismatch(input string msg);
      if (mismatches < 40) begin
         $display("%0t ERROR: %s", $realtime, msg);
      end
      mismatches++;
   endtask

   function automatic out_type clip(input longint value);
      if (value > longint'(OUT_MAX)) begin
         return OUT_MAX;
      end
      if (value < longint'(OUT_MIN)) begin
         return OUT_MIN;
      end
      return out_type'(value);
   endfunction

   // second-order compensation for one raw pressure / temperature pair
   function automatic void compensate(input logic [RAW_W-1:0] d1_raw,
                                      input logic [RAW_W-1:0] d2_raw,
                                      output out_type press_out,
                                      output out_type temp_out);
      longint d1, d2, dt, off, sens, temp, off2, sens2, delta, sq;
      d1    = longint'(d1_raw);
      d2    = longint'(d2_raw);
      dt    = d2 - (longint'(cal_word[CAL_TREF]) <<< 8);
      off   = (longint'(cal_word[CAL_OFF]) <<< 16)
            + ((dt * longint'(cal_word[CAL_TCO])) >>> OFF_SHIFT);
      sens  = (longint'(cal_word[CAL_SENS]) <<< 15)
            + ((dt * longint'(cal_word[CAL_TCS])) >>> SENS_SHIFT);
      temp  = longint'(TEMP_REF) + ((dt * longint'(cal_word[CAL_TEMPSENS])) >>> TEMP_SHIFT);
      off2  = 0;
      sens2 = 0;
      if (temp < longint'(TEMP_REF)) begin
         delta = temp - longint'(TEMP_REF);
         sq    = delta * delta;
         off2  = (5 * sq) >>> 1;
         sens2 = (5 * sq) >>> 2;
         if (temp < longint'(TEMP_LOW)) begin
            delta = temp - longint'(TEMP_LOW);
            sq    = delta * delta;
            off2  = off2 + 7 * sq;
            sens2 = sens2 + ((11 * sq) >>> 1);
         end
      end
      off       = off - off2;
      sens      = sens - sens2;
      press_out = clip((((d1 * sens) >>> PROD_SHIFT) - off) >>> PRESS_SHIFT);
      temp_out  = clip(temp);
   endfunction

   always @(posedge clock) begin : watch
      reading_type fresh;
      reading_type want;
      out_type     got_press;
      out_type     got_temp;
      if (reset) begin
         cal_word = CAL_RESET;
         compensated_q.delete();
      end else begin
         if (csr_valid && csr_ready && csr_index < CAL_NUM) begin
            cal_word[csr_index] = csr_data;
         end
         if (req_tvalid && req_tready) begin
            fresh.raw_press = req_tdata[RAW_W-1:0];
            fresh.raw_temp  = req_tdata[2*RAW_W-1:RAW_W];
            compensate(fresh.raw_press, fresh.raw_temp, fresh.pressure, fresh.temperature);
            compensated_q.push_back(fresh);
         end
         if (rsp_tvalid && rsp_tready) begin
            got_press = rsp_tdata[OUT_W-1:0];
            got_temp  = rsp_tdata[2*OUT_W-1:OUT_W];
            if (compensated_q.size() == 0) begin
               report_mismatch($sformatf("unexpected word pressure %0d temperature %0d",
                                         got_press, got_temp));
            end else begin
               want = compensated_q.pop_front();
               if (got_press !== want.pressure) begin
                  report_mismatch($sformatf("pressure %0d, want %0d (d1 %0d d2 %0d)",
                                            got_press, want.pressure,
                                            want.raw_press, want.raw_temp));
               end
               if (got_temp !== want.temperature) begin
                  report_mismatch($sformatf("temperature %0d, want %0d (d1 %0d d2 %0d)",
                                            got_temp, want.temperature,
                                            want.raw_press, want.raw_temp));
               end
            end
         end
      end
      waiting = compensated_q.size();
   end

endmodule

/* dv/tb_baro_pressure_compensation_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_baro_pressure_compensation_unit
// Drives raw pressure / temperature words through the compensation unit under
// several calibration sets (reset words, all zeros, all ones, alternating
// bits, random and near-typical). A directed set covers the raw extremes and
// the 20.00 C and -15.00 C thresholds, then random words weighted toward the
// temperature thresholds follow. Both sides stall in random bursts, once the
// response side holds off long enough to back up the pipeline. The checker
// module predicts and compares every response word.
// ----------------------------------------------------------------------------
module tb_baro_pressure_compensation_unit;
   import bpc_pkg::*;

   localparam int PHASES         = 8;
   localparam int WORDS_PER_SET  = 235;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SETTLE         = STAGES + 3;
   localparam logic [RAW_W-1:0] RAW_ALL = '1;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [47:0]          req_tdata;   // raw_pressure, raw_temperature
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [39:0]          rsp_tdata;   // pressure, temperature, pad
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CAL_IDX_W-1:0] csr_index;
   logic [15:0]          csr_data;

   int           fail_count;
   int           pending;
   cal_word_type cal_now [CAL_NUM];
   int           gap_pct = 0;
   int           rsp_stall_pct = 0;
   bit           quiet = 1'b0;
   bit           hold_request = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   baro_pressure_compensation_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   bpc_compensation_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // raw temperature that lands near a target temperature under the current words
   function automatic logic [RAW_W-1:0] temp_raw(input longint target, input longint offset);
      longint d2;
      d2 = (longint'(cal_now[CAL_TREF]) <<< 8) + offset;
      if (cal_now[CAL_TEMPSENS] != 0) begin
         d2 = d2 + ((target - longint'(TEMP_REF)) * (longint'(1) <<< TEMP_SHIFT))
                   / longint'(cal_now[CAL_TEMPSENS]);
      end
      if (d2 < 0) begin
         d2 = 0;
      end
      if (d2 > longint'(RAW_ALL)) begin
         d2 = longint'(RAW_ALL);
      end
      return d2[RAW_W-1:0];
   endfunction

   function automatic logic [47:0] pick_pair();
      logic [RAW_W-1:0] d1;
      logic [RAW_W-1:0] d2;
      int               kind;
      longint           jitter;
      d1     = RAW_W'($urandom);
      kind   = $urandom_range(99);
      jitter = longint'($urandom_range(4000)) - 2000;
      if (kind < 30) begin
         d2 = RAW_W'($urandom);
      end else if (kind < 55) begin
         d2 = temp_raw(longint'(TEMP_REF), longint'($urandom_range(1 << 21)) - (1 << 20));
      end else if (kind < 75) begin
         d2 = temp_raw(longint'(TEMP_REF), jitter);
      end else if (kind < 88) begin
         d2 = temp_raw(longint'(TEMP_LOW), jitter);
      end else if (kind < 93) begin
         d2 = temp_raw(longint'(TEMP_LOW) - longint'($urandom_range(60000)), jitter);
      end else begin
         d1 = ($urandom_range(1) != 0) ? RAW_ALL : '0;
         case ($urandom_range(2))
            0:       d2 = '0;
            1:       d2 = RAW_ALL;
            default: d2 = temp_raw(longint'(TEMP_REF), 0);
         endcase
      end
      return {d2, d1};
   endfunction

   task automatic send_pair(input logic [RAW_W-1:0] d1, input logic [RAW_W-1:0] d2);
      req_tvalid <= 1'b1;
      req_tdata  <= {d2, d1};
      do @(posedge clock); while (!req_tready);
      if (!quiet && $urandom_range(99) < gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
   endtask

   task automatic send_random(input int count);
      logic [47:0] word;
      for (int n = 0; n < count; n++) begin
         word = pick_pair();
         send_pair(word[RAW_W-1:0], word[2*RAW_W-1:RAW_W]);
      end
   endtask

   // a clock edge first so the count includes the last accepted word
   task automatic drain_pipeline();
      req_tvalid <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   // indexes past the last word are written too; the unit must drop them
   task automatic load_cal(input cal_word_type words [CAL_NUM]);
      for (int i = 0; i < CAL_NUM + 2; i++) begin
         csr_valid <= 1'b1;
         csr_index <= cal_idx_type'(i);
         csr_data  <= (i < CAL_NUM) ? words[i] : cal_word_type'($urandom);
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
      cal_now = words;
   endtask

   initial begin : receiver
      int stall_left;
      int hold_count;
      stall_left = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_tready <= 1'b0;
            hold_count = 0;
            while (hold_count < HOLD_CYCLES) begin
               @(posedge clock);
               hold_count++;
            end
            hold_request = 1'b0;
         end else if (stall_left > 0 && !quiet) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else if (!quiet && $urandom_range(99) < rsp_stall_pct) begin
            rsp_tready <= 1'b0;
            stall_left = $urandom_range(17);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
             || (csr_valid && csr_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("watchdog: no handshake for %0d cycles, %0d words outstanding",
               WATCHDOG_LIMIT, pending);
      $display("baro_pressure_compensation_unit: mismatch");
      $finish;
   end

   initial begin : stimulus
      cal_word_type words [CAL_NUM];
      longint       offsets [5];
      logic [RAW_W-1:0] typical;
      offsets = '{-600, -300, 0, 300, 600};
      typical = 24'd9085466;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_valid  <= 1'b0;
      csr_index  <= '0;
      csr_data   <= '0;
      cal_now    = CAL_RESET;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed words under the reset calibration
      gap_pct       = 10;
      rsp_stall_pct = 10;
      send_pair('0, '0);
      send_pair(RAW_ALL, RAW_ALL);
      send_pair('0, RAW_ALL);
      send_pair(RAW_ALL, '0);
      send_pair(24'hAAAAAA, 24'h555555);
      send_pair(24'h555555, 24'hAAAAAA);
      foreach (offsets[k]) begin
         send_pair(typical, temp_raw(longint'(TEMP_REF), offsets[k]));
         send_pair(typical, temp_raw(longint'(TEMP_LOW), offsets[k]));
      end
      send_pair(RAW_ALL, temp_raw(longint'(TEMP_LOW) - 20000, 0));
      send_pair(typical, temp_raw(longint'(TEMP_REF) + 6000, 0));
      send_random(WORDS_PER_SET);

      for (int phase = 1; phase < PHASES; phase++) begin
         drain_pipeline();
         for (int i = 0; i < CAL_NUM; i++) begin
            case (phase)
               1:       words[i] = '0;
               2:       words[i] = '1;
               3:       words[i] = (i % 2 == 0) ? 16'hAAAA : 16'h5555;
               4:       words[i] = (i % 2 == 0) ? 16'h5555 : 16'hAAAA;
               5, 6:    words[i] = cal_word_type'($urandom);
               default: words[i] = CAL_RESET[i] + cal_word_type'($urandom_range(8192)) - 16'd4096;
            endcase
         end
         load_cal(words);
         gap_pct       = $urandom_range(3) * 8;
         rsp_stall_pct = $urandom_range(3) * 8;
         if (phase == 2) begin
            hold_request = 1'b1;
         end
         if (phase == PHASES - 1) begin
            send_random(WORDS_PER_SET / 2);
            quiet = 1'b1;
            send_random(WORDS_PER_SET - WORDS_PER_SET / 2);
         end else begin
            send_random(WORDS_PER_SET);
         end
      end

      drain_pipeline();
      if (fail_count == 0) begin
         $display("baro_pressure_compensation_unit: match");
      end else begin
         $display("baro_pressure_compensation_unit: mismatch");
      end
      $finish;
   end

endmodule
